// ===== hw/rtl/assert_macros.svh =====
// assertion macros of the pose distance block, used by se3_pose_distance
// expects clk and rst in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define CHK_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define CHK_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/se3pd_pkg.sv =====
// package for the se3 pose distance block: constants, register codes, pipeline records
// no dependencies; used by se3pd_isqrt and se3_pose_distance
package se3pd_pkg;

  localparam int unsigned ISQRT_STEPS  = 32;
  localparam int unsigned CORDIC_STEPS = 32;
  localparam int unsigned DIV_STEPS    = 31;

  localparam logic [32:0] ONE_Q32        = 33'h1_0000_0000;
  localparam logic [33:0] EPS_Q32        = 34'd42950;
  localparam logic [63:0] PI_QUARTER_Q32 = 64'd3373259426;
  localparam logic [24:0] RMAX2 = 25'((64'd306274118 * 64'd306274118) >> 32);
  localparam logic [24:0] RMIN2 = 25'((64'd85899346 * 64'd85899346) >> 32);
  localparam logic [24:0] RDIFF = RMAX2 - RMIN2;

  typedef enum logic [2:0] {
    REG_QUERY_X  = 3'd0,
    REG_QUERY_Y  = 3'd1,
    REG_QUERY_Z  = 3'd2,
    REG_QUERY_QW = 3'd3,
    REG_QUERY_QX = 3'd4,
    REG_QUERY_QY = 3'd5,
    REG_QUERY_QZ = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [32:0] c;
    logic [36:0] az;
    logic        czero;
  } sq_side_t;

  typedef struct packed {
    logic [32:0] c;
    logic [32:0] s;
    logic [36:0] az;
    logic [31:0] tr;
    logic        tsat;
  } cd_side_t;

  typedef struct packed {
    logic [33:0] angle;
    logic        small_ang;
    logic [34:0] sn;
    logic        satc;
    logic [31:0] tr;
    logic        tsat;
  } dv_side_t;

  typedef struct packed {
    logic [33:0] angle;
    logic        small_ang;
    logic [31:0] tr;
    logic        tsat;
  } rs_side_t;

  // arctangent of 2^-i in Q.32, taylor series in Q.62 rounded half up
  function automatic logic [63:0] atan_entry(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned k;
    sum = '0;
    if (i == 0) begin
      return PI_QUARTER_Q32;
    end
    for (k = 0; i * (2 * k + 1) < 62; k++) begin
      term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return (sum + (64'd1 << 29)) >> 30;
  endfunction

  // arithmetic right shift that rounds toward zero
  function automatic logic signed [63:0] shr_tz(input logic signed [63:0] v,
                                                input int unsigned n);
    logic signed [63:0] neg;
    neg = -v;
    if (v[63]) begin
      return -(neg >>> n);
    end
    return v >>> n;
  endfunction

endpackage

// ===== hw/rtl/se3_pose_distance.sv =====
// top level of the se3 pose distance block: query registers and the full pipeline
// depends on se3pd_pkg, se3pd_isqrt and assert_macros.svh
//
//   channel    handshake             payload
//   request    start / busy          cand_x cand_y cand_z cand_qw cand_qx cand_qy cand_qz
//   result     done (one cycle)      distance
//   config     cfg_valid / cfg_ready cfg_index cfg_data
//
// one request enters per clock; busy is never raised and cfg_ready is always high
// results appear in request order
// the depth is set by the 32 stage sine root (the translation root runs beside it),
// the 32 stage cordic, the 31 stage divider and the 32 stage radius root, in series
// rst is synchronous: it empties the pipeline and restores the identity query pose
// the result side cannot stall, so the pipeline advances every cycle
`include "assert_macros.svh"

module se3_pose_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] cand_x,
  input  logic signed [31:0] cand_y,
  input  logic signed [31:0] cand_z,
  input  logic signed [17:0] cand_qw,
  input  logic signed [17:0] cand_qx,
  input  logic signed [17:0] cand_qy,
  input  logic signed [17:0] cand_qz,
  output logic               done,
  output logic [31:0]        distance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import se3pd_pkg::*;

  localparam int unsigned LATENCY = 5 + ISQRT_STEPS + 1 + CORDIC_STEPS + 2 + DIV_STEPS
                                    + 3 + ISQRT_STEPS + 2;

  // query pose registers
  logic signed [31:0] query_x, query_y, query_z;
  logic signed [17:0] query_qw, query_qx, query_qy, query_qz;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_x  <= '0;
      query_y  <= '0;
      query_z  <= '0;
      query_qw <= 18'sd65536;
      query_qx <= '0;
      query_qy <= '0;
      query_qz <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_QUERY_X:  query_x  <= cfg_data;
        REG_QUERY_Y:  query_y  <= cfg_data;
        REG_QUERY_Z:  query_z  <= cfg_data;
        REG_QUERY_QW: query_qw <= cfg_data[17:0];
        REG_QUERY_QX: query_qx <= cfg_data[17:0];
        REG_QUERY_QY: query_qy <= cfg_data[17:0];
        REG_QUERY_QZ: query_qz <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // stage 0: capture the candidate
  logic               v0;
  logic signed [31:0] s0_x, s0_y, s0_z;
  logic signed [17:0] s0_qw, s0_qx, s0_qy, s0_qz;

  always_ff @(posedge clk) begin
    s0_x  <= cand_x;
    s0_y  <= cand_y;
    s0_z  <= cand_z;
    s0_qw <= cand_qw;
    s0_qx <= cand_qx;
    s0_qy <= cand_qy;
    s0_qz <= cand_qz;
  end

  // stage 1: quaternion partial products and absolute position deltas
  logic               v1;
  logic signed [35:0] pw [4];
  logic signed [35:0] pz [4];
  logic [31:0]        m1 [3];
  logic               big1;
  logic signed [32:0] dlt [3];
  logic [32:0]        mag [3];

  assign dlt[0] = 33'(query_x) - 33'(s0_x);
  assign dlt[1] = 33'(query_y) - 33'(s0_y);
  assign dlt[2] = 33'(query_z) - 33'(s0_z);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = dlt[i][32] ? 33'(-dlt[i]) : 33'(dlt[i]);
    end
  end

  always_ff @(posedge clk) begin
    pw[0] <= s0_qw * query_qw;
    pw[1] <= s0_qx * query_qx;
    pw[2] <= s0_qy * query_qy;
    pw[3] <= s0_qz * query_qz;
    pz[0] <= s0_qw * query_qz;
    pz[1] <= s0_qx * query_qy;
    pz[2] <= s0_qy * query_qx;
    pz[3] <= s0_qz * query_qw;
    for (int i = 0; i < 3; i++) begin
      m1[i] <= mag[i][31:0];
    end
    big1 <= mag[0][32] | mag[1][32] | mag[2][32];
  end

  // stage 2: relative w and z, squared deltas
  logic               v2;
  logic signed [37:0] w2, z2;
  logic [63:0]        sq2 [3];
  logic               big2;

  always_ff @(posedge clk) begin
    w2 <= 38'(pw[0]) + 38'(pw[1]) + 38'(pw[2]) + 38'(pw[3]);
    z2 <= 38'(pz[2]) + 38'(pz[3]) - 38'(pz[0]) - 38'(pz[1]);
    for (int i = 0; i < 3; i++) begin
      sq2[i] <= 64'(m1[i]) * 64'(m1[i]);
    end
    big2 <= big1;
  end

  // stage 3: clipped |w|, |z|, sum of squares with overflow check
  logic        v3;
  logic [32:0] c3;
  logic [36:0] az3;
  logic        czero3;
  logic [63:0] tsum3;
  logic        tsat3;
  logic [37:0] absw;
  logic [37:0] absz;
  logic [65:0] tsum_full;

  assign absw      = w2[37] ? 38'(-w2) : 38'(w2);
  assign absz      = z2[37] ? 38'(-z2) : 38'(z2);
  assign tsum_full = 66'(sq2[0]) + 66'(sq2[1]) + 66'(sq2[2]);

  always_ff @(posedge clk) begin
    c3     <= (absw > 38'(ONE_Q32)) ? ONE_Q32 : absw[32:0];
    czero3 <= (absw == '0);
    az3    <= absz[36:0];
    tsum3  <= tsum_full[63:0];
    tsat3  <= big2 | (tsum_full[65:64] != 2'b00);
  end

  // stage 4: 1 - c^2 for the sine root
  logic        v4;
  logic [63:0] p4;
  logic [66:0] p4_full;
  sq_side_t    sq4;
  logic [63:0] tsum4;
  logic        tsat4;

  assign p4_full = 67'(ONE_Q32 - c3) * 67'(34'(ONE_Q32) + 34'(c3));

  always_ff @(posedge clk) begin
    p4        <= p4_full[63:0];
    sq4.c     <= c3;
    sq4.az    <= az3;
    sq4.czero <= czero3;
    tsum4     <= tsum3;
    tsat4     <= tsat3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // sine root and translation root run side by side
  logic        sa_valid, st_valid;
  logic [31:0] s_root, t_root;
  sq_side_t    sa_side;
  logic        st_sat;

  se3pd_isqrt #(.SIDE_W($bits(sq_side_t))) u_sine_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .radicand  (p4),
    .in_side   (sq4),
    .out_valid (sa_valid),
    .root      (s_root),
    .out_side  (sa_side)
  );

  se3pd_isqrt #(.SIDE_W(1)) u_trans_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .radicand  (tsum4),
    .in_side   (tsat4),
    .out_valid (st_valid),
    .root      (t_root),
    .out_side  (st_sat)
  );

  // cordic vectoring for the half angle atan2(s, c)
  logic signed [63:0] cx_q [CORDIC_STEPS+1];
  logic signed [63:0] cy_q [CORDIC_STEPS+1];
  logic signed [63:0] cz_q [CORDIC_STEPS+1];
  cd_side_t           cs_q [CORDIC_STEPS+1];
  logic               cv_q [CORDIC_STEPS+1];
  logic [32:0]        s_sel;

  assign s_sel = sa_side.czero ? ONE_Q32 : {1'b0, s_root};

  always_ff @(posedge clk) begin
    cx_q[0]      <= 64'(sa_side.c);
    cy_q[0]      <= 64'(s_sel);
    cz_q[0]      <= '0;
    cs_q[0].c    <= sa_side.c;
    cs_q[0].s    <= s_sel;
    cs_q[0].az   <= sa_side.az;
    cs_q[0].tr   <= t_root;
    cs_q[0].tsat <= st_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv_q[0] <= 1'b0;
    end else begin
      cv_q[0] <= sa_valid && st_valid;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [63:0] ATAN_I = atan_entry(i);
    logic signed [63:0] xs, ys;

    assign xs = shr_tz(cx_q[i], i);
    assign ys = shr_tz(cy_q[i], i);

    always_ff @(posedge clk) begin
      if (cy_q[i] > 0) begin
        cx_q[i+1] <= cx_q[i] + ys;
        cy_q[i+1] <= cy_q[i] - xs;
        cz_q[i+1] <= cz_q[i] + ATAN_I;
      end else begin
        cx_q[i+1] <= cx_q[i] - ys;
        cy_q[i+1] <= cy_q[i] + xs;
        cz_q[i+1] <= cz_q[i] - ATAN_I;
      end
      cs_q[i+1] <= cs_q[i];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cv_q[i+1] <= 1'b0;
      end else begin
        cv_q[i+1] <= cv_q[i];
      end
    end
  end

  // angle stage: clamp, double, epsilon test; sine of the angle as 2cs
  logic        va;
  logic [33:0] ang_a;
  logic        small_a;
  logic [34:0] sn_a;
  logic [36:0] az_a;
  logic [31:0] tr_a;
  logic        tsat_a;
  logic signed [63:0] hz;
  logic [32:0] h_clamp;
  logic [65:0] cs_prod;
  cd_side_t    cd_end;

  assign hz      = cz_q[CORDIC_STEPS];
  assign cd_end  = cs_q[CORDIC_STEPS];
  assign h_clamp = hz[63] ? '0 : hz[32:0];
  assign cs_prod = 66'(cd_end.c) * 66'(cd_end.s);

  always_ff @(posedge clk) begin
    ang_a   <= {h_clamp, 1'b0};
    small_a <= ({h_clamp, 1'b0} <= EPS_Q32);
    sn_a    <= cs_prod[65:31];
    az_a    <= cd_end.az;
    tr_a    <= cd_end.tr;
    tsat_a  <= cd_end.tsat;
  end

  // divider set-up: saturation test and dividend |z| << 30
  logic [67:0] dv_rem  [DIV_STEPS+1];
  logic [30:0] dv_quo  [DIV_STEPS+1];
  dv_side_t    dv_side [DIV_STEPS+1];
  logic        dv_v    [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    dv_rem[0]            <= 68'(az_a) << 30;
    dv_quo[0]            <= '0;
    dv_side[0].angle     <= ang_a;
    dv_side[0].small_ang <= small_a;
    dv_side[0].sn        <= sn_a;
    dv_side[0].satc      <= (sn_a == '0) || (38'(az_a) >= (38'(sn_a) << 1));
    dv_side[0].tr        <= tr_a;
    dv_side[0].tsat      <= tsat_a;
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int unsigned SH = DIV_STEPS - 1 - j;
    logic [67:0] dsh;

    assign dsh = 68'(dv_side[j].sn) << SH;

    always_ff @(posedge clk) begin
      if (dv_rem[j] >= dsh) begin
        dv_rem[j+1] <= dv_rem[j] - dsh;
        dv_quo[j+1] <= dv_quo[j] | (31'd1 << SH);
      end else begin
        dv_rem[j+1] <= dv_rem[j];
        dv_quo[j+1] <= dv_quo[j];
      end
      dv_side[j+1] <= dv_side[j];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else begin
        dv_v[j+1] <= dv_v[j];
      end
    end
  end

  // m1: cos^2, m2: scaled by rmax^2 - rmin^2, m3: ellipse radicand
  logic        vm1, vm2, vm3;
  logic [33:0] cos2_m1;
  logic [33:0] t_m2;
  logic [24:0] rad2_m3;
  rs_side_t    rs_m1, rs_m2, rs_m3;
  logic [31:0] cosa;
  logic [63:0] cosa_sq;
  logic [63:0] t_prod;
  dv_side_t    dv_end;

  assign dv_end  = dv_side[DIV_STEPS];
  assign cosa    = dv_end.satc ? 32'h8000_0000 : {1'b0, dv_quo[DIV_STEPS]};
  assign cosa_sq = 64'(cosa) * 64'(cosa);
  assign t_prod  = 64'(cos2_m1) * 64'(RDIFF);

  always_ff @(posedge clk) begin
    cos2_m1         <= cosa_sq[63:30];
    rs_m1.angle     <= dv_end.angle;
    rs_m1.small_ang <= dv_end.small_ang;
    rs_m1.tr        <= dv_end.tr;
    rs_m1.tsat      <= dv_end.tsat;
    t_m2            <= t_prod[63:30];
    rs_m2           <= rs_m1;
    rad2_m3         <= (34'(RMAX2) > t_m2) ? 25'(34'(RMAX2) - t_m2) : '0;
    rs_m3           <= rs_m2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
      va      <= 1'b0;
      vm1     <= 1'b0;
      vm2     <= 1'b0;
      vm3     <= 1'b0;
    end else begin
      va      <= cv_q[CORDIC_STEPS];
      dv_v[0] <= va;
      vm1     <= dv_v[DIV_STEPS];
      vm2     <= vm1;
      vm3     <= vm2;
    end
  end

  // ellipse radius
  logic        vr;
  logic [31:0] radius;
  rs_side_t    rs_r;

  se3pd_isqrt #(.SIDE_W($bits(rs_side_t))) u_radius_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vm3),
    .radicand  ({7'd0, rad2_m3, 32'd0}),
    .in_side   (rs_m3),
    .out_valid (vr),
    .root      (radius),
    .out_side  (rs_r)
  );

  // m4: rotation term, m5: saturating sum into the result register
  logic        vm4;
  logic [17:0] rot_m4;
  logic [31:0] tr_m4;
  logic        tsat_m4;
  logic [65:0] ra_prod;
  logic [32:0] total;

  assign ra_prod = 66'(radius) * 66'(rs_r.angle);
  assign total   = 33'(tr_m4) + 33'(rot_m4);

  always_ff @(posedge clk) begin
    rot_m4  <= rs_r.small_ang ? '0 : ra_prod[65:48];
    tr_m4   <= rs_r.tr;
    tsat_m4 <= rs_r.tsat;
    if (tsat_m4 || total[32]) begin
      distance <= '1;
    end else begin
      distance <= total[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm4  <= 1'b0;
      done <= 1'b0;
    end else begin
      vm4  <= vr;
      done <= vm4;
    end
  end

  // checks
  `CHK_PROP(a_result_latency, done |-> $past(accept, LATENCY),
            "result without a request LATENCY cycles earlier")
  `CHK_PROP(a_trans_sat, (vm4 && tsat_m4) |=> (done && distance == 32'hFFFF_FFFF),
            "translation overflow did not saturate the distance")
  `CHK_NEVER(a_div_rem, dv_v[DIV_STEPS] && !dv_end.satc &&
             dv_rem[DIV_STEPS] >= 68'(dv_end.sn),
             "divider remainder not below divisor")

endmodule

// ===== hw/rtl/se3pd_isqrt.sv =====
// pipelined 64 bit integer square root, one result bit per register stage
// depends on se3pd_pkg; sideband data travels alongside each radicand
module se3pd_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       radicand,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [31:0]       root,
  output logic [SIDE_W-1:0] out_side
);
  import se3pd_pkg::*;

  logic [63:0]       v_q    [ISQRT_STEPS];
  logic [63:0]       r_q    [ISQRT_STEPS];
  logic [SIDE_W-1:0] side_q [ISQRT_STEPS];
  logic              val_q  [ISQRT_STEPS];

  for (genvar i = 0; i < ISQRT_STEPS; i++) begin : g_st
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0]       v_in;
    logic [63:0]       r_in;
    logic [SIDE_W-1:0] side_in;
    logic              val_in;
    logic [64:0]       trial;

    if (i == 0) begin : g_first
      assign v_in    = radicand;
      assign r_in    = '0;
      assign side_in = in_side;
      assign val_in  = in_valid;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign r_in    = r_q[i-1];
      assign side_in = side_q[i-1];
      assign val_in  = val_q[i-1];
    end

    assign trial = {1'b0, r_in} + {1'b0, BIT};

    always_ff @(posedge clk) begin
      if ({1'b0, v_in} >= trial) begin
        v_q[i] <= v_in - trial[63:0];
        r_q[i] <= (r_in >> 1) + BIT;
      end else begin
        v_q[i] <= v_in;
        r_q[i] <= r_in >> 1;
      end
      side_q[i] <= side_in;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        val_q[i] <= 1'b0;
      end else begin
        val_q[i] <= val_in;
      end
    end
  end

  assign out_valid = val_q[ISQRT_STEPS-1];
  assign root      = r_q[ISQRT_STEPS-1][31:0];
  assign out_side  = side_q[ISQRT_STEPS-1];

endmodule
